// File: rtl/fxalu_pkg.sv
// Shared types, codes and saturation helper for the Q24.8 fixed-point ALU.
package fxalu_pkg;

    localparam int FRACTION_BITS_DEFAULT = 8;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_CMP      = 4'd8,
        OP_TO_INT   = 4'd9,
        OP_FROM_INT = 4'd10
    } fxalu_kind_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]  kind;
        logic        div_neg;
        logic        less;
        logic        equal;
        logic        greater;
        logic [31:0] value;
        logic [1:0]  status;
    } fxalu_side_t;

    // Sign and magnitude to a clamped 32-bit word; top bit flags saturation.
    function automatic logic [32:0] sat_pack(input logic neg, input logic [63:0] mag);
        logic [32:0] res;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                res = {1'b1, WORD_MIN};
            end else begin
                res = {1'b0, 32'd0 - mag[31:0]};
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                res = {1'b1, WORD_MAX};
            end else begin
                res = {1'b0, mag[31:0]};
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/fxalu_front.sv
// Front stages: operand decode, simple operations, multiply and its rounding.
module fxalu_front #(
    parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEFAULT,
    localparam int NUM_W = 32 + FRACTION_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [3:0]                kind,
    input  logic signed [31:0]        operand_a,
    input  logic signed [31:0]        operand_b,
    output logic                      out_valid,
    output fxalu_pkg::fxalu_side_t    side,
    output logic [NUM_W-1:0]          num,
    output logic [31:0]               den
);

    localparam logic [63:0] HALF_LSB = 64'd1 << (FRACTION_BITS - 1);

    function automatic logic [32:0] sat33(input logic [32:0] s);
        logic [32:0] res;
        if (s[32] != s[31]) begin
            res = {1'b1, s[32] ? fxalu_pkg::WORD_MIN : fxalu_pkg::WORD_MAX};
        end else begin
            res = {1'b0, s[31:0]};
        end
        return res;
    endfunction

    logic [31:0]           mag_a;
    logic [31:0]           mag_b;
    logic [32:0]           ext_a;
    logic [32:0]           ext_b;
    logic [32:0]           sat_res;
    logic [31:0]           int_part;
    fxalu_pkg::fxalu_side_t s1_side_next;

    logic                   s1_valid_reg;
    fxalu_pkg::fxalu_side_t s1_side_reg;
    logic [NUM_W-1:0]       s1_num_reg;
    logic [31:0]            s1_den_reg;

    logic                   s2_valid_reg;
    fxalu_pkg::fxalu_side_t s2_side_reg;
    logic [NUM_W-1:0]       s2_num_reg;
    logic [31:0]            s2_den_reg;
    logic [63:0]            s2_prod_reg;

    logic                   s3_valid_reg;
    fxalu_pkg::fxalu_side_t s3_side_reg;
    fxalu_pkg::fxalu_side_t s3_side_next;
    logic [NUM_W-1:0]       s3_num_reg;
    logic [31:0]            s3_den_reg;
    logic [32:0]            mul_res;

    always_comb
    begin
        mag_a    = operand_a[31] ? (32'd0 - 32'(operand_a)) : 32'(operand_a);
        mag_b    = operand_b[31] ? (32'd0 - 32'(operand_b)) : 32'(operand_b);
        ext_a    = {operand_a[31], operand_a};
        ext_b    = {operand_b[31], operand_b};
        int_part = mag_a >> FRACTION_BITS;
        sat_res  = 33'd0;

        s1_side_next.kind    = kind;
        s1_side_next.div_neg = operand_a[31] ^ operand_b[31];
        s1_side_next.less    = operand_a < operand_b;
        s1_side_next.equal   = operand_a == operand_b;
        s1_side_next.greater = operand_a > operand_b;
        s1_side_next.value   = 32'd0;
        s1_side_next.status  = fxalu_pkg::ST_OK;

        unique case (kind)
            fxalu_pkg::OP_ADD:      sat_res = sat33(ext_a + ext_b);
            fxalu_pkg::OP_SUB:      sat_res = sat33(ext_a - ext_b);
            fxalu_pkg::OP_INC:      sat_res = sat33(ext_a + 33'd1);
            fxalu_pkg::OP_DEC:      sat_res = sat33(ext_a - 33'd1);
            fxalu_pkg::OP_MIN:      sat_res = {1'b0, (operand_b < operand_a) ? operand_b : operand_a};
            fxalu_pkg::OP_MAX:      sat_res = {1'b0, (operand_b > operand_a) ? operand_b : operand_a};
            fxalu_pkg::OP_TO_INT:
            begin
                sat_res = {1'b0, operand_a[31] ? (32'd0 - int_part) : int_part};
            end
            fxalu_pkg::OP_FROM_INT:
            begin
                sat_res = fxalu_pkg::sat_pack(operand_a[31], 64'(mag_a) << FRACTION_BITS);
            end
            default:                sat_res = 33'd0;
        endcase

        s1_side_next.value = sat_res[31:0];
        if (sat_res[32]) begin
            s1_side_next.status = fxalu_pkg::ST_SAT;
        end
        if (kind == fxalu_pkg::OP_DIV && mag_b == 32'd0) begin
            s1_side_next.status = fxalu_pkg::ST_DIV0;
        end
    end

    always_comb
    begin
        mul_res      = fxalu_pkg::sat_pack(s2_side_reg.div_neg,
                                           (s2_prod_reg + HALF_LSB) >> FRACTION_BITS);
        s3_side_next = s2_side_reg;
        if (s2_side_reg.kind == fxalu_pkg::OP_MUL) begin
            s3_side_next.value  = mul_res[31:0];
            s3_side_next.status = mul_res[32] ? fxalu_pkg::ST_SAT : fxalu_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_side_reg <= s1_side_next;
            s1_num_reg  <= {mag_a, FRACTION_BITS'(0)};
            s1_den_reg  <= mag_b;
            s2_side_reg <= s1_side_reg;
            s2_num_reg  <= s1_num_reg;
            s2_den_reg  <= s1_den_reg;
            s2_prod_reg <= 64'(s1_num_reg[NUM_W-1:FRACTION_BITS]) * 64'(s1_den_reg);
            s3_side_reg <= s3_side_next;
            s3_num_reg  <= s2_num_reg;
            s3_den_reg  <= s2_den_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign side      = s3_side_reg;
    assign num       = s3_num_reg;
    assign den       = s3_den_reg;

endmodule

// File: rtl/fxalu_div_step.sv
// One restoring-division stage: one quotient bit per stage.
module fxalu_div_step #(
    parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEFAULT,
    localparam int NUM_W = 32 + FRACTION_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  fxalu_pkg::fxalu_side_t    in_side,
    input  logic [NUM_W-1:0]          in_numquo,
    input  logic [31:0]               in_rem,
    input  logic [31:0]               in_den,
    output logic                      out_valid,
    output fxalu_pkg::fxalu_side_t    out_side,
    output logic [NUM_W-1:0]          out_numquo,
    output logic [31:0]               out_rem,
    output logic [31:0]               out_den
);

    logic [32:0]            trial;
    logic [32:0]            diff;
    logic                   qbit;
    logic [31:0]            rem_next;
    logic [NUM_W-1:0]       numquo_next;

    logic                   valid_reg;
    fxalu_pkg::fxalu_side_t side_reg;
    logic [NUM_W-1:0]       numquo_reg;
    logic [31:0]            rem_reg;
    logic [31:0]            den_reg;

    always_comb
    begin
        trial       = {in_rem, in_numquo[NUM_W-1]};
        diff        = trial - {1'b0, in_den};
        qbit        = trial >= {1'b0, in_den};
        rem_next    = qbit ? diff[31:0] : trial[31:0];
        numquo_next = {in_numquo[NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            side_reg   <= in_side;
            numquo_reg <= numquo_next;
            rem_reg    <= rem_next;
            den_reg    <= in_den;
        end
    end

    assign out_valid  = valid_reg;
    assign out_side   = side_reg;
    assign out_numquo = numquo_reg;
    assign out_rem    = rem_reg;
    assign out_den    = den_reg;

endmodule

// File: rtl/fixed_point_q24_8_alu_unit.sv
// Top level of the pipelined signed Q24.8 fixed-point ALU.
//
// Channel   Dir  Signals                   Contents (lowest bit first)
// s_axis    in   tvalid tready tdata tuser tdata: operand_a, operand_b; tuser: kind
// m_axis    out  tvalid tready tdata tuser tdata: value, less, equal, greater; tuser: status
//
// One item enters per cycle unless a result is stalled on m_axis; there are three
// front stages, 32 + FRACTION_BITS divider stages and one round-and-select stage.
// The divider chain sets the depth; every operation travels the full pipeline.
// Reset clears only the valid bits. The whole pipeline holds while a result
// waits on m_axis; bubbles inside it are not squeezed out.
module fixed_point_q24_8_alu_unit #(
    parameter int FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [3:0]  s_axis_tuser,   // kind[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value[31:0], less[32], equal[33], greater[34], zero[39:35]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int NUM_W = 32 + FRACTION_BITS;

    logic                   en;
    logic                   stg_valid  [0:NUM_W];
    fxalu_pkg::fxalu_side_t stg_side   [0:NUM_W];
    logic [NUM_W-1:0]       stg_numquo [0:NUM_W];
    logic [31:0]            stg_rem    [0:NUM_W];
    logic [31:0]            stg_den    [0:NUM_W];

    logic [63:0]            q_rnd;
    logic [32:0]            div_res;
    fxalu_pkg::fxalu_side_t fin_side;
    logic                   round_up;

    logic                   out_valid_reg;
    fxalu_pkg::fxalu_side_t out_side_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    fxalu_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .kind      (s_axis_tuser),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .out_valid (stg_valid[0]),
        .side      (stg_side[0]),
        .num       (stg_numquo[0]),
        .den       (stg_den[0])
    );

    assign stg_rem[0] = 32'd0;

    for (genvar i = 0; i < NUM_W; i++) begin : g_div
        fxalu_div_step #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (stg_valid[i]),
            .in_side    (stg_side[i]),
            .in_numquo  (stg_numquo[i]),
            .in_rem     (stg_rem[i]),
            .in_den     (stg_den[i]),
            .out_valid  (stg_valid[i+1]),
            .out_side   (stg_side[i+1]),
            .out_numquo (stg_numquo[i+1]),
            .out_rem    (stg_rem[i+1]),
            .out_den    (stg_den[i+1])
        );
    end

    always_comb
    begin
        round_up = {stg_rem[NUM_W], 1'b0} >= {1'b0, stg_den[NUM_W]};
        q_rnd    = 64'(stg_numquo[NUM_W]) + 64'(round_up);
        div_res  = fxalu_pkg::sat_pack(stg_side[NUM_W].div_neg, q_rnd);
        fin_side = stg_side[NUM_W];
        if (stg_side[NUM_W].kind == fxalu_pkg::OP_DIV
            && stg_side[NUM_W].status != fxalu_pkg::ST_DIV0) begin
            fin_side.value  = div_res[31:0];
            fin_side.status = div_res[32] ? fxalu_pkg::ST_SAT : fxalu_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= stg_valid[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_side_reg <= fin_side;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_side_reg.greater, out_side_reg.equal,
                            out_side_reg.less, out_side_reg.value};
    assign m_axis_tuser  = out_side_reg.status;

endmodule

// File: verif/tb_fixed_point_q24_8_alu_unit.sv
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU stream unit.
`timescale 1ns / 100ps

module tb_fixed_point_q24_8_alu_unit;
    import fxalu_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEFAULT;
    localparam int LATENCY = FRAC + 36;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_TAIL = 150;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [31:0] value;
        logic        less;
        logic        equal;
        logic        greater;
        logic [1:0]  status;
    } alu_result_t;

    class fxalu_scoreboard;
        alu_result_t pending_results[$];
        int errors;
        int checked;
        int kind_seen[16];
        int sat_seen;
        int div0_seen;

        function longint mag_of(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function logic [31:0] clamp32(longint v, inout logic [1:0] st);
            if (v > 64'sd2147483647) begin
                st = ST_SAT;
                return WORD_MAX;
            end
            if (v < -64'sd2147483648) begin
                st = ST_SAT;
                return WORD_MIN;
            end
            return v[31:0];
        endfunction

        function void note_operation(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
            longint sa;
            longint sb;
            longint sgn;
            bit [63:0] ma;
            bit [63:0] mb;
            bit [63:0] q;
            alu_result_t e;
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            ma = mag_of(sa);
            mb = mag_of(sb);
            sgn = ((sa < 0) != (sb < 0)) ? -1 : 1;
            e.status = ST_OK;
            e.value = '0;
            case (kind)
                OP_ADD:  e.value = clamp32(sa + sb, e.status);
                OP_SUB:  e.value = clamp32(sa - sb, e.status);
                OP_MUL:
                begin
                    q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                    e.value = clamp32(sgn * longint'(q), e.status);
                end
                OP_DIV:
                begin
                    if (mb == 0) begin
                        e.status = ST_DIV0;
                    end else begin
                        q = (2 * (ma << FRAC) + mb) / (2 * mb);
                        e.value = clamp32(sgn * longint'(q), e.status);
                    end
                end
                OP_MIN:  e.value = (sb < sa) ? b : a;
                OP_MAX:  e.value = (sb > sa) ? b : a;
                OP_INC:  e.value = clamp32(sa + 1, e.status);
                OP_DEC:  e.value = clamp32(sa - 1, e.status);
                OP_CMP:  e.value = '0;
                OP_TO_INT:
                    e.value = clamp32(((sa < 0) ? -1 : 1) * longint'(ma >> FRAC), e.status);
                OP_FROM_INT:
                    e.value = clamp32(((sa < 0) ? -1 : 1) * longint'(ma << FRAC), e.status);
                default: e.value = '0;
            endcase
            e.less = sa < sb;
            e.equal = sa == sb;
            e.greater = sa > sb;
            kind_seen[kind]++;
            if (e.status == ST_SAT) sat_seen++;
            if (e.status == ST_DIV0) div0_seen++;
            pending_results.push_back(e);
        endfunction

        function void check_result(logic [31:0] value, logic lt, logic eq, logic gt,
                                   logic [4:0] pad, logic [1:0] status);
            alu_result_t e;
            if (pending_results.size() == 0) begin
                $error("result with none expected: value %h status %0d", value, status);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (value !== e.value) begin
                $error("value: expected %h, actual %h", e.value, value);
                errors++;
            end
            if (lt !== e.less) begin
                $error("less: expected %b, actual %b", e.less, lt);
                errors++;
            end
            if (eq !== e.equal) begin
                $error("equal: expected %b, actual %b", e.equal, eq);
                errors++;
            end
            if (gt !== e.greater) begin
                $error("greater: expected %b, actual %b", e.greater, gt);
                errors++;
            end
            if (pad !== 5'd0) begin
                $error("pad: expected %h, actual %h", 5'd0, pad);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    bit idle_on = 1'b1;
    int idle_cycles = 0;
    fxalu_scoreboard alu_board = new();

    fixed_point_q24_8_alu_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                alu_board.note_operation(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                alu_board.check_result(m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                                       m_axis_tdata[34], m_axis_tdata[39:35], m_axis_tuser);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: stall in short bursts while idling is enabled.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic drive(input logic [3:0] kind, input logic [31:0] a, input logic [31:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tuser <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom;
            2: v = 32'($urandom_range(0, 4095)) - 32'd2048;
            3:
            begin
                case ($urandom_range(0, 7))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = 32'd0;
                    3: v = 32'd1;
                    4: v = 32'hFFFF_FFFF;
                    5: v = 32'h0000_0100;
                    6: v = 32'hFFFF_FF00;
                    default: v = 32'h7FFF_FF00;
                endcase
            end
            4: v = $urandom >> $urandom_range(0, 31);
            5: v = 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
            default: v = $urandom >> $urandom_range(8, 24);
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    initial begin
        logic [3:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        drive(OP_ADD, WORD_MAX, 32'd1);
        drive(OP_ADD, 32'h0000_0100, 32'h0000_0180);
        drive(OP_SUB, WORD_MIN, 32'd1);
        drive(OP_SUB, 32'd0, WORD_MIN);
        drive(OP_MUL, 32'h0000_0180, 32'h0000_0280);
        drive(OP_MUL, 32'd1, 32'h0000_0080);
        drive(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
        drive(OP_MUL, WORD_MAX, WORD_MAX);
        drive(OP_MUL, WORD_MIN, 32'hFFFF_FFFF);
        drive(OP_DIV, 32'h0000_0500, 32'd0);
        drive(OP_DIV, 32'd1, 32'h0000_0200);
        drive(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
        drive(OP_DIV, WORD_MAX, 32'd1);
        drive(OP_MIN, 32'h0000_1234, 32'h0000_1234);
        drive(OP_MAX, WORD_MIN, WORD_MAX);
        drive(OP_INC, WORD_MAX, 32'd0);
        drive(OP_DEC, WORD_MIN, 32'd5);
        drive(OP_INC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drive(OP_CMP, WORD_MIN, WORD_MAX);
        drive(OP_TO_INT, 32'hFFFF_FE80, 32'd0);
        drive(OP_TO_INT, WORD_MIN, WORD_MIN);
        drive(OP_FROM_INT, 32'h007F_FFFF, 32'd0);
        drive(OP_FROM_INT, 32'h0080_0000, 32'd0);
        drive(OP_FROM_INT, 32'hFF80_0000, 32'd0);
        drive(4'd15, 32'd3, 32'd7);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = (i < RANDOM_ITEMS - CALM_TAIL) && ((i / 100) % 3 != 2);
            kind = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
            a = random_operand();
            case ($urandom_range(0, 9))
                0: b = a;
                1: b = 32'd0;
                default: b = random_operand();
            endcase
            drive(kind, a, b);
        end
        s_axis_tvalid <= 1'b0;

        while (alu_board.pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("checked %0d results over 11 operations and unused codes", alu_board.checked);
        $display("saturated results: %0d, divisions by zero: %0d, mismatches: %0d",
                 alu_board.sat_seen, alu_board.div0_seen, alu_board.errors);
        if (alu_board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
